>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge, masked while rst_ni is low.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/pfd_pkg.sv
`default_nettype none

package pfd_pkg;

  localparam int unsigned WinLen  = 32;
  localparam int unsigned NumRead = 9;
  localparam int unsigned FirstRd = 10;
  localparam int unsigned OutBits = 1 + 16 * NumRead;
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8;

  localparam logic [7:0] HdrA    = 8'h42;
  localparam logic [7:0] HdrB    = 8'h4D;
  localparam logic [7:0] BodyLen = 8'd28;

  localparam logic StatusGood = 1'b0;
  localparam logic StatusCsum = 1'b1;

  // byte 0 oldest, byte WinLen-1 newest
  typedef logic [WinLen-1:0][7:0] win_t;

endpackage

`default_nettype wire

>>> rtl/pfd_cell.sv
`default_nettype none

module pfd_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = shift_i ? byte_i : byte_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

>>> rtl/pfd_frame.sv
`default_nettype none

module pfd_frame (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fresh_i,
  input  pfd_pkg::win_t          win_i,
  input  logic [15:0]            sum_i,
  output logic                   stall_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // status, mass_small, mass_fine, mass_coarse, count_0p3, count_0p5,
  // count_1p0, count_2p5, count_5p0, count_10p0, zero pad
  output logic [pfd_pkg::OutW-1:0] m_axis_tdata_o
);

  import pfd_pkg::*;

  logic            hit, good, load;
  logic            valid_q, valid_d;
  logic [OutW-1:0] data_q, data_d;

  assign hit  = (win_i[0] == HdrA) && (win_i[1] == HdrB) &&
                (win_i[2] == 8'd0) && (win_i[3] == BodyLen);
  assign good = (sum_i == {win_i[WinLen-2], win_i[WinLen-1]});

  // a pending frame may only move on once the output beat has gone
  assign load    = fresh_i && hit && (!valid_q || m_axis_tready_i);
  assign stall_o = fresh_i && hit && valid_q && !m_axis_tready_i;

  always_comb begin
    data_d    = '0;
    data_d[0] = good ? StatusGood : StatusCsum;
    for (int k = 0; k < NumRead; k++) begin
      data_d[1 + 16 * k +: 16] = good ?
        {win_i[FirstRd + 2 * k], win_i[FirstRd + 2 * k + 1]} : 16'd0;
    end
  end

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;

endmodule

`default_nettype wire

>>> rtl/particle_frame_deframer_top.sv
// A byte that completes a frame has its result beat registered in u_frame.
// Throughput: one byte per cycle; the input stalls only while a frame result
// waits behind an unaccepted output beat.
// The 32-byte window is a row of byte cells; the 16-bit running sum is updated
// with one add and one subtract per beat.
// Reset (rst_ni low, asynchronous) zeroes the window and sum and drops tvalid.
`default_nettype none

module particle_frame_deframer_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // rx_byte
  input  logic [7:0]               s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // status, mass_small, mass_fine, mass_coarse, count_0p3, count_0p5,
  // count_1p0, count_2p5, count_5p0, count_10p0, zero pad
  output logic [pfd_pkg::OutW-1:0] m_axis_tdata_o
);

  import pfd_pkg::*;

  `include "assert_macros.svh"

  logic        accept, stall;
  logic        fresh_q, fresh_d;
  logic [15:0] sum_q, sum_d;
  win_t        win;

  assign s_axis_tready_o = !stall;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  for (genvar i = 0; i < WinLen; i++) begin : g_cell
    logic [7:0] nxt;
    if (i == WinLen - 1) begin : g_head
      assign nxt = s_axis_tdata_i;
    end else begin : g_body
      assign nxt = win[i+1];
    end
    pfd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .byte_i  (nxt),
      .byte_o  (win[i])
    );
  end

  // sum over bytes 0..29: byte 30 moves into the span, byte 0 drops out
  always_comb begin
    sum_d = accept ? (sum_q + {8'd0, win[WinLen-2]} - {8'd0, win[0]}) : sum_q;
  end

  always_comb begin
    fresh_d = accept || stall;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      fresh_q <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      fresh_q <= fresh_d;
    end
  end

  pfd_frame u_frame (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fresh_i         (fresh_q),
    .win_i           (win),
    .sum_i           (sum_q),
    .stall_o         (stall),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  `ASSERT_RST(a_stall_needs_full, !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i && fresh_q), "input stalled without a blocked result")
  `ASSERT_RST(a_csum_err_zero, (m_axis_tvalid_o && m_axis_tdata_o[0] == StatusCsum) |-> (m_axis_tdata_o[OutW-1:1] == '0), "checksum error beat carries readings")
  `ASSERT_RST(a_accept_fresh, accept |=> fresh_q, "accepted byte not marked for checking")
  `ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid_o, "result valid straight after reset")

endmodule

`default_nettype wire
